>>> design/bpc_pkg.sv
// Package for the barometric pressure and temperature compensation core.
// Holds the payload and trim types, datapath widths and the rounding helper.
// No dependencies.
package bpc_pkg;

   // Number of register stages from the input item to the result register.
   localparam int unsigned PIPE_DEPTH = 19;

   // Datapath widths, sized from the bounds of the trim words and raw inputs.
   localparam int unsigned RAW_W  = 24;
   localparam int unsigned D_W    = 25;
   localparam int unsigned NT_W   = 61;
   localparam int unsigned TQ_W   = 41;
   localparam int unsigned SQ2_W  = 48;
   localparam int unsigned SQ3_W  = 56;
   localparam int unsigned DQ_W   = 50;
   localparam int unsigned C_W    = 60;
   localparam int unsigned A_W    = 56;
   localparam int unsigned RND_W  = 128;
   localparam int unsigned CSR_DATA_W = 48;

   // Saturation limits of the two results.
   localparam int TEMP_MAX  = 8388607;
   localparam int TEMP_MIN  = -8388608;
   localparam int PRESS_MAX = 16777215;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_TEMP_TRIM  = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_MID  = 2'd2,
      CSR_PRESS_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] temperature_out;
      logic [23:0]        pressure_out;
      logic               clipped;
   } rsp_payload_type;

   // Trim words split into their fields; signedness is applied where used.
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [7:0]  t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [7:0]  p3;
      logic [7:0]  p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [7:0]  p7;
      logic [7:0]  p8;
      logic [15:0] p9;
      logic [7:0]  p10;
      logic [7:0]  p11;
   } trim_type;

   // What the temperature section hands to the pressure section.
   typedef struct packed {
      logic [RAW_W-1:0] rp;
      logic [23:0]      tv;
      logic [TQ_W-1:0]  tq;
      logic             clip;
   } temp_stage_type;

   // Fields carried alongside the pressure polynomial.
   typedef struct packed {
      logic [RAW_W-1:0] rp;
      logic [23:0]      tv;
      logic             clip;
   } carry_type;

   function automatic trim_type trim_decode(input logic [39:0] temp_trim,
                                            input logic [31:0] press_low,
                                            input logic [47:0] press_mid,
                                            input logic [47:0] press_high);
      trim_type t;
      t.t1  = temp_trim[15:0];
      t.t2  = temp_trim[31:16];
      t.t3  = temp_trim[39:32];
      t.p1  = press_low[15:0];
      t.p2  = press_low[31:16];
      t.p3  = press_mid[7:0];
      t.p4  = press_mid[15:8];
      t.p5  = press_mid[31:16];
      t.p6  = press_mid[47:32];
      t.p7  = press_high[7:0];
      t.p8  = press_high[15:8];
      t.p9  = press_high[31:16];
      t.p10 = press_high[39:32];
      t.p11 = press_high[47:40];
      return t;
   endfunction

   // Divide by 2^s, rounding half away from zero. Called with constant s >= 1.
   function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [RND_W-1:0] x,
                                                         input int unsigned s);
      logic signed [RND_W-1:0] half;
      logic signed [RND_W-1:0] sum;
      half = RND_W'(1) <<< (s - 1);
      sum  = x + half - RND_W'(x[RND_W-1]);
      return sum >>> s;
   endfunction

endpackage

>>> design/bpc_mul.sv
// Two-stage signed multiplier built from four registered partial products.
// Depends on nothing; used by the temperature and pressure sections.
module bpc_mul #(
   parameter int unsigned WA = 32,
   parameter int unsigned WB = 32
) (
   input  logic                      clock,
   input  logic                      advance,
   input  logic signed [WA-1:0]      a,
   input  logic signed [WB-1:0]      b,
   output logic signed [WA+WB-1:0]   product
);

   localparam int unsigned LA = WA / 2;
   localparam int unsigned HA = WA - LA;
   localparam int unsigned LB = WB / 2;
   localparam int unsigned HB = WB - LB;
   localparam int unsigned WP = WA + WB;

   logic signed [LA:0]          a_lo;
   logic signed [HA-1:0]        a_hi;
   logic signed [LB:0]          b_lo;
   logic signed [HB-1:0]        b_hi;
   logic signed [LA+LB+1:0]     pp_ll_in, pp_ll_ff;
   logic signed [LA+HB:0]       pp_lh_in, pp_lh_ff;
   logic signed [HA+LB:0]       pp_hl_in, pp_hl_ff;
   logic signed [HA+HB-1:0]     pp_hh_in, pp_hh_ff;
   logic signed [WP-1:0]        product_in, product_ff;

   // Split each operand into an unsigned low half and a signed high half.
   assign a_lo = $signed({1'b0, a[LA-1:0]});
   assign a_hi = a[WA-1:LA];
   assign b_lo = $signed({1'b0, b[LB-1:0]});
   assign b_hi = b[WB-1:LB];

   assign pp_ll_in = a_lo * b_lo;
   assign pp_lh_in = a_lo * b_hi;
   assign pp_hl_in = a_hi * b_lo;
   assign pp_hh_in = a_hi * b_hi;

   // First stage: the four partial products.
   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
      end
   end

   // Second stage: weight and sum the partial products.
   assign product_in = (WP'(pp_hh_ff) <<< (LA + LB)) + (WP'(pp_hl_ff) <<< LA)
                     + (WP'(pp_lh_ff) <<< LB) + WP'(pp_ll_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

>>> design/bpc_temp.sv
// Temperature section: linearized temperature from the raw sample, six stages.
// Depends on bpc_pkg and bpc_mul.
module bpc_temp
   import bpc_pkg::*;
(
   input  logic            clock,
   input  logic            advance,
   input  req_payload_type req_data,
   input  trim_type        trim,
   output temp_stage_type  stage_out
);

   logic [RAW_W-1:0]        rp_ff [5];
   logic signed [D_W-1:0]   d_in, d_ff;
   logic signed [41:0]      pdt2_in, pdt2_ff [3];
   logic signed [49:0]      pdd_in, pdd_ff;
   logic signed [57:0]      m_prod;
   logic signed [NT_W-1:0]  nt_in, nt_ff;
   logic signed [NT_W-1:0]  tv_full;
   logic signed [TQ_W-1:0]  tq_full;
   logic signed [23:0]      tv_sat;
   logic                    clip;
   temp_stage_type          stage_in, stage_ff;

   // Stage 1: offset of the raw temperature from its trim point.
   assign d_in = $signed({1'b0, req_data.raw_temperature}) - $signed({1'b0, trim.t1, 8'b0});

   // Stage 2: linear and square terms of the offset.
   assign pdt2_in = d_ff * $signed({1'b0, trim.t2});
   assign pdd_in  = d_ff * d_ff;

   // Stages 3 and 4: square term scaled by the signed curvature trim.
   bpc_mul #(.WA(50), .WB(8)) u_curv (
      .clock   (clock),
      .advance (advance),
      .a       (pdd_ff),
      .b       ($signed(trim.t3)),
      .product (m_prod)
   );

   // Stage 5: temperature scaled by 2^32.
   assign nt_in = (NT_W'(pdt2_ff[2]) <<< 18) + NT_W'(m_prod);

   // Stage 6: round, saturate and form the Q16 temperature.
   assign tv_full = NT_W'(rnd_shift(RND_W'(nt_ff), 32));
   assign tq_full = TQ_W'(rnd_shift(RND_W'(nt_ff), 16));

   always_comb begin
      clip   = 1'b0;
      tv_sat = tv_full[23:0];
      if (tv_full > NT_W'(TEMP_MAX)) begin
         tv_sat = 24'(TEMP_MAX);
         clip   = 1'b1;
      end else if (tv_full < NT_W'(TEMP_MIN)) begin
         tv_sat = 24'(TEMP_MIN);
         clip   = 1'b1;
      end
      stage_in.rp   = rp_ff[4];
      stage_in.tv   = tv_sat;
      stage_in.tq   = clip ? (TQ_W'(tv_sat) <<< 16) : tq_full;
      stage_in.clip = clip;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rp_ff[0]   <= req_data.raw_pressure;
         rp_ff[1]   <= rp_ff[0];
         rp_ff[2]   <= rp_ff[1];
         rp_ff[3]   <= rp_ff[2];
         rp_ff[4]   <= rp_ff[3];
         d_ff       <= d_in;
         pdt2_ff[0] <= pdt2_in;
         pdt2_ff[1] <= pdt2_ff[0];
         pdt2_ff[2] <= pdt2_ff[1];
         pdd_ff     <= pdd_in;
         nt_ff      <= nt_in;
         stage_ff   <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> design/bpc_press.sv
// Pressure section: polynomial in temperature and raw pressure, thirteen stages.
// Depends on bpc_pkg and bpc_mul; ends in the result register.
module bpc_press
   import bpc_pkg::*;
(
   input  logic            clock,
   input  logic            advance,
   input  temp_stage_type  stage_in,
   input  trim_type        trim,
   output rsp_payload_type rsp_data
);

   // Trim fields in signed form.
   logic signed [16:0] p1m, p2m, p5s, p6s;
   logic signed [15:0] p9s;
   logic signed [D_W-1:0] rp6;

   assign p1m = 17'($signed(trim.p1)) - 17'sd16384;
   assign p2m = 17'($signed(trim.p2)) - 17'sd16384;
   assign p5s = $signed({1'b0, trim.p5});
   assign p6s = $signed({1'b0, trim.p6});
   assign p9s = $signed(trim.p9);
   assign rp6 = $signed({1'b0, stage_in.rp});

   // Stages 7 and 8: products of the Q16 temperature and raw pressure.
   logic signed [2*TQ_W-1:0]  q_tt;
   logic signed [17+TQ_W-1:0] q_p2, q_p6;
   logic signed [8+TQ_W-1:0]  q_p10;
   logic signed [2*D_W-1:0]   q_rr;
   logic signed [D_W+7:0]     q_rp11;
   temp_stage_type            s7_ff, s8_ff, s9_ff;

   bpc_mul #(.WA(TQ_W), .WB(TQ_W)) u_tt (
      .clock(clock), .advance(advance),
      .a($signed(stage_in.tq)), .b($signed(stage_in.tq)), .product(q_tt));
   bpc_mul #(.WA(17), .WB(TQ_W)) u_p2 (
      .clock(clock), .advance(advance),
      .a(p2m), .b($signed(stage_in.tq)), .product(q_p2));
   bpc_mul #(.WA(17), .WB(TQ_W)) u_p6 (
      .clock(clock), .advance(advance),
      .a(p6s), .b($signed(stage_in.tq)), .product(q_p6));
   bpc_mul #(.WA(8), .WB(TQ_W)) u_p10 (
      .clock(clock), .advance(advance),
      .a($signed(trim.p10)), .b($signed(stage_in.tq)), .product(q_p10));
   bpc_mul #(.WA(D_W), .WB(D_W)) u_rr (
      .clock(clock), .advance(advance),
      .a(rp6), .b(rp6), .product(q_rr));
   bpc_mul #(.WA(D_W), .WB(8)) u_rp11 (
      .clock(clock), .advance(advance),
      .a(rp6), .b($signed(trim.p11)), .product(q_rp11));

   // Stage 9: square of temperature, first coefficient terms.
   logic signed [SQ2_W-1:0]  sq2_in, sq2_ff;
   logic signed [C_W-1:0]    c9_in, c9_ff;
   logic signed [A_W-1:0]    a9_in, a9_ff;
   logic signed [DQ_W-1:0]   dq_in, dq_ff;
   logic signed [2*D_W-1:0]  rr_ff;
   logic signed [D_W+7:0]    rp11_ff;

   assign sq2_in = SQ2_W'(rnd_shift(RND_W'(q_tt), 32));
   assign c9_in  = (C_W'(p1m) <<< 40) + C_W'(rnd_shift(RND_W'(q_p2), 1));
   assign a9_in  = (A_W'(p5s) <<< 33) + A_W'(rnd_shift(RND_W'(q_p6), 8));
   assign dq_in  = (DQ_W'(p9s) <<< 32) + DQ_W'(q_p10);

   // Stages 10 and 11: cube of temperature and second-order products.
   logic signed [SQ2_W+TQ_W-1:0]   q_s3;
   logic signed [8+SQ2_W-1:0]      q_p3, q_p7;
   logic signed [2*D_W+DQ_W-1:0]   q_rd;
   logic signed [2*D_W+D_W+7:0]    q_r11;

   bpc_mul #(.WA(SQ2_W), .WB(TQ_W)) u_s3 (
      .clock(clock), .advance(advance),
      .a(sq2_ff), .b($signed(s9_ff.tq)), .product(q_s3));
   bpc_mul #(.WA(8), .WB(SQ2_W)) u_p3 (
      .clock(clock), .advance(advance),
      .a($signed(trim.p3)), .b(sq2_ff), .product(q_p3));
   bpc_mul #(.WA(8), .WB(SQ2_W)) u_p7 (
      .clock(clock), .advance(advance),
      .a($signed(trim.p7)), .b(sq2_ff), .product(q_p7));
   bpc_mul #(.WA(2*D_W), .WB(DQ_W)) u_rd (
      .clock(clock), .advance(advance),
      .a(rr_ff), .b(dq_ff), .product(q_rd));
   bpc_mul #(.WA(2*D_W), .WB(D_W+8)) u_r11 (
      .clock(clock), .advance(advance),
      .a(rr_ff), .b(rp11_ff), .product(q_r11));

   // Carry line for raw pressure, temperature and clip flag from stage 10 on.
   carry_type o_ff [9];

   // Partial sums are held in short delay lines while products are formed.
   logic signed [C_W-1:0] c_dly_ff [2];
   logic signed [A_W-1:0] a_dly_ff [2];

   // Stage 12: cube rounded, more terms summed.
   logic signed [SQ3_W-1:0] sq3_in, sq3_ff;
   logic signed [C_W-1:0]   c12_in, c12_ff;
   logic signed [A_W-1:0]   a12_in, a12_ff;

   assign sq3_in = SQ3_W'(rnd_shift(RND_W'(q_s3), 32));
   assign c12_in = c_dly_ff[1] + C_W'(rnd_shift(RND_W'(q_p3), 4));
   assign a12_in = a_dly_ff[1] + A_W'(rnd_shift(RND_W'(q_p7), 10))
                 + A_W'(rnd_shift(RND_W'(q_rd), 50)) + A_W'(rnd_shift(RND_W'(q_r11), 35));

   // Stages 13 and 14: cube terms.
   logic signed [8+SQ3_W-1:0] q_p4, q_p8;
   logic signed [C_W-1:0]     c_dly2_ff [2];
   logic signed [A_W-1:0]     a_dly2_ff [2];

   bpc_mul #(.WA(8), .WB(SQ3_W)) u_p4 (
      .clock(clock), .advance(advance),
      .a($signed(trim.p4)), .b(sq3_ff), .product(q_p4));
   bpc_mul #(.WA(8), .WB(SQ3_W)) u_p8 (
      .clock(clock), .advance(advance),
      .a($signed(trim.p8)), .b(sq3_ff), .product(q_p8));

   // Stage 15: linear coefficient complete.
   logic signed [C_W-1:0] cq_in, cq_ff;
   logic signed [A_W-1:0] a15_in, a15_ff;

   assign cq_in  = c_dly2_ff[1] + C_W'(rnd_shift(RND_W'(q_p4), 9));
   assign a15_in = a_dly2_ff[1] + A_W'(rnd_shift(RND_W'(q_p8), 17));

   // Stages 16 and 17: raw pressure times the linear coefficient.
   logic signed [D_W+C_W-1:0] q_rc;
   logic signed [A_W-1:0]     a_dly3_ff [2];

   bpc_mul #(.WA(D_W), .WB(C_W)) u_rc (
      .clock(clock), .advance(advance),
      .a($signed({1'b0, o_ff[5].rp})), .b(cq_ff), .product(q_rc));

   // Stage 18: full accumulator.
   logic signed [A_W-1:0] acc_in, acc_ff;

   assign acc_in = a_dly3_ff[1] + A_W'(rnd_shift(RND_W'(q_rc), 30));

   // Stage 19: pressure rounded and saturated into the result register.
   logic signed [A_W-1:0] pr_full;
   logic [23:0]           pv;
   logic                  pclip;
   rsp_payload_type       rsp_in, rsp_ff;

   assign pr_full = A_W'(rnd_shift(RND_W'(acc_ff), 24));

   always_comb begin
      pclip = 1'b0;
      pv    = pr_full[23:0];
      if (pr_full < A_W'(0)) begin
         pv    = '0;
         pclip = 1'b1;
      end else if (pr_full > A_W'(PRESS_MAX)) begin
         pv    = 24'(PRESS_MAX);
         pclip = 1'b1;
      end
      rsp_in.temperature_out = $signed(o_ff[8].tv);
      rsp_in.pressure_out    = pv;
      rsp_in.clipped         = o_ff[8].clip | pclip;
   end

   // All payload registers move together when the pipeline advances.
   always_ff @(posedge clock) begin
      if (advance) begin
         s7_ff        <= stage_in;
         s8_ff        <= s7_ff;
         s9_ff        <= s8_ff;
         sq2_ff       <= sq2_in;
         c9_ff        <= c9_in;
         a9_ff        <= a9_in;
         dq_ff        <= dq_in;
         rr_ff        <= q_rr;
         rp11_ff      <= q_rp11;
         o_ff[0]      <= '{rp: s9_ff.rp, tv: s9_ff.tv, clip: s9_ff.clip};
         for (int i = 1; i < 9; i++) begin
            o_ff[i] <= o_ff[i-1];
         end
         c_dly_ff[0]  <= c9_ff;
         c_dly_ff[1]  <= c_dly_ff[0];
         a_dly_ff[0]  <= a9_ff;
         a_dly_ff[1]  <= a_dly_ff[0];
         sq3_ff       <= sq3_in;
         c12_ff       <= c12_in;
         a12_ff       <= a12_in;
         c_dly2_ff[0] <= c12_ff;
         c_dly2_ff[1] <= c_dly2_ff[0];
         a_dly2_ff[0] <= a12_ff;
         a_dly2_ff[1] <= a_dly2_ff[0];
         cq_ff        <= cq_in;
         a15_ff       <= a15_in;
         a_dly3_ff[0] <= a15_ff;
         a_dly3_ff[1] <= a_dly3_ff[0];
         acc_ff       <= acc_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> design/baro_pressure_temp_compensation_core.sv
// Accepted items flow to their results at one item per cycle while no result is stalled.
// The depth is set by the chain temperature, its square, its cube, the cube
// terms of the linear coefficient, and raw pressure times that coefficient.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
// Reset (synchronous) clears the trim registers and every valid bit.
module baro_pressure_temp_compensation_core
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [39:0]           temp_trim_ff;
   logic [31:0]           press_low_ff;
   logic [47:0]           press_mid_ff;
   logic [47:0]           press_high_ff;
   trim_type              trim;
   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;
   temp_stage_type        temp_stage;

   // Trim registers; writes are always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff  <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_TRIM:  temp_trim_ff  <= csr_wdata[39:0];
            CSR_PRESS_LOW:  press_low_ff  <= csr_wdata[31:0];
            CSR_PRESS_MID:  press_mid_ff  <= csr_wdata[47:0];
            CSR_PRESS_HIGH: press_high_ff <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   assign trim = trim_decode(temp_trim_ff, press_low_ff, press_mid_ff, press_high_ff);

   // The pipeline moves unless a finished item is waiting on a stalled output.
   assign advance   = !(valid_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   bpc_temp u_temp (
      .clock     (clock),
      .advance   (advance),
      .req_data  (req_data),
      .trim      (trim),
      .stage_out (temp_stage)
   );

   bpc_press u_press (
      .clock    (clock),
      .advance  (advance),
      .stage_in (temp_stage),
      .trim     (trim),
      .rsp_data (rsp_data)
   );

endmodule

>>> design/bpc_checker.sv
// Port-level checks for the compensation core, attached by a bind statement.
// Depends on bpc_pkg and the top-level port list.
module bpc_checker
   import bpc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data,
   input logic            csr_valid,
   input logic            csr_ready
);

   // A result held by the consumer stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Input is held back only by a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Trim writes are never refused.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind baro_pressure_temp_compensation_core bpc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the barometric compensation core.
// Drives raw pressure/temperature items, predicts every result in fixed point
// and compares each field; depends on bpc_pkg and the core RTL.
module tb
   import bpc_pkg::*;
();

   localparam int IDLE_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_TEMP_TRIM;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Trim registers as the predictor sees them.
   logic [39:0] temp_trim_q;
   logic [31:0] press_low_q;
   logic [47:0] press_mid_q;
   logic [47:0] press_high_q;

   rsp_payload_type expected_q[$];
   int  err_count = 0;
   int  burst_left = 4;
   bit  hold_req = 0;
   int  quiet_cycles = 0;

   baro_pressure_temp_compensation_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Round a*b / 2^s half away from zero, saturating to the 64-bit range.
   function automatic longint mul_round(input longint a, input longint b, input int s);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic [127:0]        mag;
      bit                  neg;
      wa = 128'(a);
      wb = 128'(b);
      neg = (a < 0) != (b < 0);
      if (wa < 0) wa = -wa;
      if (wb < 0) wb = -wb;
      mag = wa * wb;
      if (s > 0) mag = (mag + (128'd1 << (s - 1))) >> s;
      if (mag > 128'h7FFF_FFFF_FFFF_FFFF) mag = 128'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   // Compensated temperature and pressure for one raw pair.
   function automatic rsp_payload_type compensate(input req_payload_type raw);
      rsp_payload_type r;
      longint t1, t2c, t3c, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
      longint rp, d, nt, tv, tq, sq2, sq3, cq, dq, rp2, acc, pv;
      bit clip;
      t1  = longint'(temp_trim_q[15:0]);
      t2c = longint'(temp_trim_q[31:16]);
      t3c = longint'($signed(temp_trim_q[39:32]));
      p1  = longint'($signed(press_low_q[15:0]));
      p2  = longint'($signed(press_low_q[31:16]));
      p3  = longint'($signed(press_mid_q[7:0]));
      p4  = longint'($signed(press_mid_q[15:8]));
      p5  = longint'(press_mid_q[31:16]);
      p6  = longint'(press_mid_q[47:32]);
      p7  = longint'($signed(press_high_q[7:0]));
      p8  = longint'($signed(press_high_q[15:8]));
      p9  = longint'($signed(press_high_q[31:16]));
      p10 = longint'($signed(press_high_q[39:32]));
      p11 = longint'($signed(press_high_q[47:40]));
      rp = longint'(raw.raw_pressure);
      d  = longint'(raw.raw_temperature) - 256 * t1;
      nt = d * t2c * 262144 + d * d * t3c;
      tv = mul_round(nt, 1, 32);
      clip = 0;
      if (tv > TEMP_MAX) begin
         tv = longint'(TEMP_MAX);
         clip = 1;
      end else if (tv < TEMP_MIN) begin
         tv = longint'(TEMP_MIN);
         clip = 1;
      end
      tq  = clip ? tv * 65536 : mul_round(nt, 1, 16);
      sq2 = mul_round(tq, tq, 32);
      sq3 = mul_round(sq2, tq, 32);
      cq  = (p1 - 16384) * 64'sd1099511627776 + mul_round(p2 - 16384, tq, 1)
          + mul_round(p3, sq2, 4) + mul_round(p4, sq3, 9);
      dq  = p9 * 64'sd4294967296 + p10 * tq;
      rp2 = rp * rp;
      acc = p5 * 64'sd8589934592 + mul_round(p6, tq, 8) + mul_round(p7, sq2, 10)
          + mul_round(p8, sq3, 17) + mul_round(rp, cq, 30) + mul_round(rp2, dq, 50)
          + mul_round(rp2, rp * p11, 35);
      pv = mul_round(acc, 1, 24);
      if (pv < 0) begin
         pv = 64'sd0;
         clip = 1;
      end else if (pv > PRESS_MAX) begin
         pv = longint'(PRESS_MAX);
         clip = 1;
      end
      r.temperature_out = tv[23:0];
      r.pressure_out    = pv[23:0];
      r.clipped         = clip;
      return r;
   endfunction

   // Track trim writes, predict accepted items and check accepted results.
   always @(posedge clock) begin
      if (reset) begin
         temp_trim_q  <= '0;
         press_low_q  <= '0;
         press_mid_q  <= '0;
         press_high_q <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP_TRIM:  temp_trim_q  <= csr_wdata[39:0];
               CSR_PRESS_LOW:  press_low_q  <= csr_wdata[31:0];
               CSR_PRESS_MID:  press_mid_q  <= csr_wdata[47:0];
               CSR_PRESS_HIGH: press_high_q <= csr_wdata[47:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_q.push_back(compensate(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result item %p", rsp_data);
               err_count++;
            end else begin
               rsp_payload_type e;
               e = expected_q.pop_front();
               if (rsp_data.temperature_out !== e.temperature_out) begin
                  $error("temperature_out expected %0d actual %0d",
                         e.temperature_out, rsp_data.temperature_out);
                  err_count++;
               end
               if (rsp_data.pressure_out !== e.pressure_out) begin
                  $error("pressure_out expected %0d actual %0d",
                         e.pressure_out, rsp_data.pressure_out);
                  err_count++;
               end
               if (rsp_data.clipped !== e.clipped) begin
                  $error("clipped expected %0b actual %0b", e.clipped, rsp_data.clipped);
                  err_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver stall pattern, moving through four characters in turn, with a
   // single long hold-off that lets the pipeline back up.
   initial begin : receiver
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_req) begin
            hold_req = 0;
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
         end
         case ((cyc / 64) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Offer one item and hold it until accepted; bursts end in random gaps.
   task automatic send_raw(input logic [23:0] rp, input logic [23:0] rt);
      req_payload_type p;
      p.raw_pressure    = rp;
      p.raw_temperature = rt;
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Wait until every expected item is back and the pipeline is empty.
   task automatic drain;
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_trims(input logic [47:0] tt, input logic [47:0] pl,
                             input logic [47:0] pm, input logic [47:0] ph);
      drain();
      write_reg(CSR_TEMP_TRIM, tt);
      write_reg(CSR_PRESS_LOW, pl);
      write_reg(CSR_PRESS_MID, pm);
      write_reg(CSR_PRESS_HIGH, ph);
   endtask

   typedef struct {
      int              trim_sel;
      logic [23:0]     rp;
      logic [23:0]     rt;
      bit              typed;
      rsp_payload_type result;
   } stim_row_type;

   // Trim sets: reset values, a plausible part, everything high, everything low.
   logic [47:0] trim_sets[4][4] = '{
      '{48'h0, 48'h0, 48'h0, 48'h0},
      '{48'h00F9_4A38_6B6C, 48'h0000_F0A5_1F40, 48'h6AE0_6A00_F90C, 48'hF50A_1234_03E2},
      '{48'hFF7F_FFFF_0000, 48'hFFFF_7FFF_7FFF, 48'hFFFF_FFFF_7F7F, 48'h7F7F_7FFF_7F7F},
      '{48'h0080_FFFF_FFFF, 48'h0000_8000_8000, 48'h0000_0000_8080, 48'h8080_8000_8080}
   };

   // With all trims zero the temperature is zero and the pressure is -rp,
   // so any nonzero raw pressure clips at zero.
   stim_row_type directed[] = '{
      '{0, 24'h000000, 24'h000000, 1, '{24'sd0, 24'd0, 1'b0}},
      '{0, 24'hFFFFFF, 24'h000000, 1, '{24'sd0, 24'd0, 1'b1}},
      '{0, 24'h000000, 24'hFFFFFF, 1, '{24'sd0, 24'd0, 1'b0}},
      '{0, 24'hFFFFFF, 24'hFFFFFF, 1, '{24'sd0, 24'd0, 1'b1}},
      '{0, 24'h000001, 24'h123456, 1, '{24'sd0, 24'd0, 1'b1}},
      '{1, 24'h000000, 24'h6B6C00, 0, '{24'sd0, 24'd0, 1'b0}},
      '{1, 24'hFFFFFF, 24'h6B6C00, 0, '{24'sd0, 24'd0, 1'b0}},
      '{1, 24'h800000, 24'h6B6C40, 0, '{24'sd0, 24'd0, 1'b0}},
      '{1, 24'h5A0000, 24'h7A0000, 0, '{24'sd0, 24'd0, 1'b0}},
      '{1, 24'h000000, 24'h000000, 0, '{24'sd0, 24'd0, 1'b0}},
      '{1, 24'hFFFFFF, 24'hFFFFFF, 0, '{24'sd0, 24'd0, 1'b0}},
      '{2, 24'h000000, 24'hFFFFFF, 0, '{24'sd0, 24'd0, 1'b0}},
      '{2, 24'hFFFFFF, 24'hFFFFFF, 0, '{24'sd0, 24'd0, 1'b0}},
      '{2, 24'h000000, 24'h000000, 0, '{24'sd0, 24'd0, 1'b0}},
      '{2, 24'hFFFFFF, 24'h000000, 0, '{24'sd0, 24'd0, 1'b0}},
      '{3, 24'h000000, 24'h000000, 0, '{24'sd0, 24'd0, 1'b0}},
      '{3, 24'hFFFFFF, 24'h000000, 0, '{24'sd0, 24'd0, 1'b0}},
      '{3, 24'hFFFFFF, 24'hFFFFFF, 0, '{24'sd0, 24'd0, 1'b0}},
      '{3, 24'h000000, 24'hFFFF00, 0, '{24'sd0, 24'd0, 1'b0}}
   };

   initial begin : stimulus
      int cur_sel;
      int n;
      logic [47:0] tt;
      logic [23:0] rp;
      logic [23:0] rt;
      cur_sel = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; rows with a typed result are checked against it too.
      foreach (directed[i]) begin
         if (directed[i].trim_sel != cur_sel) begin
            cur_sel = directed[i].trim_sel;
            load_trims(trim_sets[cur_sel][0], trim_sets[cur_sel][1],
                       trim_sets[cur_sel][2], trim_sets[cur_sel][3]);
         end
         send_raw(directed[i].rp, directed[i].rt);
         if (directed[i].typed && compensate('{directed[i].rp, directed[i].rt})
             !== directed[i].result) begin
            $error("temperature_out/pressure_out/clipped expected %p actual %p",
                   directed[i].result, compensate('{directed[i].rp, directed[i].rt}));
            err_count++;
         end
      end

      // Random phases, each loading a trim setting: random, all ones or all zeros.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 3)
            0: tt = 48'({$urandom, $urandom});
            1: tt = '1;
            default: tt = '0;
         endcase
         if (ph % 3 == 0)
            load_trims(tt, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}));
         else
            load_trims(tt, tt, tt, tt);
         if (ph == 1) hold_req = 1;
         n = 0;
         while (n < 82) begin
            rp = 24'($urandom);
            case ($urandom_range(0, 9))
               0: rp = '0;
               1: rp = '1;
               default: ;
            endcase
            // Mostly keep the raw temperature near 256*T1 so it stays in range.
            if ($urandom_range(0, 9) < 7)
               rt = {temp_trim_q[15:0], 8'h00} + 24'($signed(17'($urandom)));
            else
               rt = 24'($urandom);
            send_raw(rp, rt);
            n++;
         end
      end

      drain();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
